// ===== rtl/fru_pkg.sv =====
// Shared types, constants and arithmetic step functions of the Fresnel refraction unit.
`default_nettype none

package fru_pkg;

    // Configuration register indexes.
    localparam logic CFG_INDEX_INSIDE  = 1'b0;
    localparam logic CFG_INDEX_OUTSIDE = 1'b1;

    localparam logic [15:0] INDEX_RESET = 16'd4096;
    localparam logic [63:0] ONE30       = 64'h0000_0000_4000_0000;
    localparam logic [23:0] SCALE_MAX   = 24'hFF_FFFF;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
    } t_req;

    typedef struct packed {
        logic signed [15:0] trans_x;
        logic signed [15:0] trans_y;
        logic signed [15:0] trans_z;
        logic [15:0]        transmit_fraction;
        logic [23:0]        radiance_scale;
        logic               total_reflect;
    } t_res;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic [2:0][16:0] n;
        logic [2:0][15:0] v;
        logic [2:0][31:0] prod;
        logic [33:0]      cdot;
        logic [15:0]      p;
        logic [15:0]      q;
        logic [30:0]      ci;
        logic [60:0]      cisq;
        logic [31:0]      qq;
        logic [31:0]      den;
        logic [30:0]      s30;
        logic [62:0]      num;
        logic             tir;
        logic [63:0]      d1_rem;
        logic [30:0]      d1_quo;
        logic [63:0]      sq_x;
        logic [63:0]      sq_r;
        logic [30:0]      ct;
        logic [46:0]      pci;
        logic [46:0]      qct;
        logic [46:0]      qci;
        logic [46:0]      pct;
        logic [47:0]      diff;
        logic [2:0][63:0] mprod;
        logic [2:0][32:0] qv;
        logic [2:0][35:0] tz;
        logic [2:0][35:0] w;
        logic [2:0][35:0] aw;
        logic [2:0]       wneg;
        logic [35:0]      mx;
        logic [2:0]       k;
        logic [2:0][29:0] am;
        logic [2:0][59:0] sqs;
        logic [61:0]      lsum;
        logic [31:0]      len;
        logic [2:0][63:0] d2_rem;
        logic [2:0][30:0] d2_quo;
        logic [2:0][15:0] t;
        logic [31:0]      fa_sum;
        logic [31:0]      fb_sum;
        logic [63:0]      fa_rem;
        logic [63:0]      fb_rem;
        logic [30:0]      fa_quo;
        logic [30:0]      fb_quo;
        logic [30:0]      ra;
        logic [30:0]      rb;
        logic [30:0]      kr;
        logic [30:0]      trans;
        logic [33:0]      dn;
        logic [47:0]      cosq;
        logic [63:0]      sc_rem;
        logic [23:0]      sc_quo;
        logic             sc_sat;
        t_res             res;
    } t_ctx;

    typedef struct packed {
        logic        q;
        logic [63:0] rem;
    } t_dv;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } t_sq;

    // One restoring division step against a pre-shifted divisor.
    function automatic t_dv div_step(input logic [63:0] rem, input logic [79:0] dsh);
        t_dv o;
        if ({16'b0, rem} >= dsh) begin
            o.q   = 1'b1;
            o.rem = rem - dsh[63:0];
        end else begin
            o.q   = 1'b0;
            o.rem = rem;
        end
        return o;
    endfunction

    // One digit of the bit-pair integer square root.
    function automatic t_sq sqrt_step(input logic [63:0] x, input logic [63:0] r,
                                      input logic [63:0] bitv);
        t_sq         o;
        logic [63:0] trial;
        trial = r + bitv;
        if (x >= trial) begin
            o.x = x - trial;
            o.r = (r >> 1) + bitv;
        end else begin
            o.x = x;
            o.r = r >> 1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fresnel_refraction_unit.sv =====
// Fresnel refraction unit: Snell refraction direction and dielectric transmittance.
`default_nettype none

// One transaction enters per clock whenever start is high; busy never rises,
// so a new surface hit can follow in the very next cycle. Each result leaves
// exactly 146 + VEC_FRAC_BITS cycles after its start edge (160 at the default
// of 14): o_done is high for that single cycle with the payload on o_res, and
// the receiver must take it then, since nothing downstream can hold the
// pipeline. The latency is set by the chain of one-bit-per-stage units: the
// cosine division, two integer square roots, the per-component normalizing
// division and the scale division. Index registers go through the cfg
// channel, which is always ready; write them only while no transaction is in
// flight. On total internal reflection the result carries total_reflect set
// and every other field zero.
module fresnel_refraction_unit
    import fru_pkg::*;
#(
    parameter int VEC_FRAC_BITS = 14
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_res,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int F = VEC_FRAC_BITS;
    // Product of two vector components back to Q1.30.
    localparam int QSHR = (2 * F >= 30) ? 2 * F - 30 : 0;
    localparam int QSHL = (2 * F < 30) ? 30 - 2 * F : 0;
    localparam logic [63:0] CM_MAX = 64'd1 << (2 * F);
    localparam logic [60:0] ONE60  = 61'd1 << 60;

    // Stage schedule: stage s computes register s+1 from register s.
    localparam int ST_NV    = 0;
    localparam int ST_DOT   = 1;
    localparam int ST_FLIP  = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_S30   = 4;
    localparam int ST_NUM   = 5;
    localparam int ST_TIR   = 6;
    localparam int ST_D1    = 7;            // 31 steps
    localparam int ST_SQ1I  = 38;
    localparam int ST_SQ1   = 39;           // 31 steps
    localparam int ST_FMUL  = 70;
    localparam int ST_FSET  = 71;
    localparam int ST_FD    = 72;           // 31 steps, alongside the direction path
    localparam int ST_MN    = 72;
    localparam int ST_TZ    = 73;
    localparam int ST_W     = 74;
    localparam int ST_ABS   = 75;
    localparam int ST_MX    = 76;
    localparam int ST_K     = 77;
    localparam int ST_AM    = 78;
    localparam int ST_SQS   = 79;
    localparam int ST_LSUM  = 80;
    localparam int ST_SQ2I  = 81;
    localparam int ST_SQ2   = 82;           // 32 steps
    localparam int ST_FR    = 103;
    localparam int ST_KR    = 104;
    localparam int ST_TRANS = 105;
    localparam int ST_D2I   = 114;
    localparam int ST_D2    = 115;          // F+1 steps
    localparam int ST_T     = 116 + F;
    localparam int ST_NT    = ST_T + 1;
    localparam int ST_DN    = ST_T + 2;
    localparam int ST_COS   = ST_T + 3;
    localparam int ST_SCI   = ST_T + 4;
    localparam int ST_SC    = ST_T + 5;     // 24 steps
    localparam int ST_FIN   = ST_T + 29;
    localparam int DEPTH    = ST_FIN + 2;

    logic [15:0]      r_index_inside;
    logic [15:0]      r_index_outside;
    logic [DEPTH-1:0] r_vld;
    t_ctx             r_pipe [DEPTH];
    t_ctx             n_in;

    // The pipeline never stalls.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_inside  <= INDEX_RESET;
            r_index_outside <= INDEX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INDEX_INSIDE:  r_index_inside  <= i_cfg_data;
                CFG_INDEX_OUTSIDE: r_index_outside <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start};
        end
    end

    // Capture the transaction; the remaining fields fill in down the line.
    always_comb begin
        n_in      = '0;
        n_in.n[0] = {i_req.normal_x[15], i_req.normal_x};
        n_in.n[1] = {i_req.normal_y[15], i_req.normal_y};
        n_in.n[2] = {i_req.normal_z[15], i_req.normal_z};
        n_in.v[0] = i_req.view_x;
        n_in.v[1] = i_req.view_y;
        n_in.v[2] = i_req.view_z;
    end

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= n_in;
    end

    for (genvar s = 0; s < DEPTH - 1; s++) begin : g_stage
        // Bit positions for the stages that belong to a one-bit-per-stage unit.
        localparam int JD1 = (s >= ST_D1 && s < ST_D1 + 31) ? ST_D1 + 30 - s : 0;
        localparam int JFD = (s >= ST_FD && s < ST_FD + 31) ? ST_FD + 30 - s : 0;
        localparam int JD2 = (s >= ST_D2 && s <= ST_D2 + F) ? ST_D2 + F - s : 0;
        localparam int JSC = (s >= ST_SC && s < ST_SC + 24) ? ST_SC + 23 - s : 0;
        localparam int ES  = (s >= ST_SQ1 && s < ST_SQ1 + 31) ? ST_SQ1 + 30 - s :
                             (s >= ST_SQ2 && s < ST_SQ2 + 32) ? ST_SQ2 + 31 - s : 0;

        t_ctx n_pipe;

        always_comb begin
            t_ctx        cur;
            logic        neg;
            logic [15:0] pin;
            logic [15:0] pout;
            logic [33:0] mag;
            logic [63:0] cm;
            logic [63:0] wide;
            logic [30:0] a_s;
            logic [30:0] b_s;
            logic [30:0] m;
            t_dv         dv;
            t_sq         sq;

            cur    = r_pipe[s];
            n_pipe = cur;
            neg    = 1'b0;
            pin    = '0;
            pout   = '0;
            mag    = '0;
            cm     = '0;
            wide   = '0;
            a_s    = '0;
            b_s    = '0;
            m      = '0;
            dv     = '0;
            sq     = '0;

            if (s == ST_NV) begin
                for (int i = 0; i < 3; i++) begin
                    n_pipe.prod[i] = 32'($signed(cur.n[i])) * 32'($signed(cur.v[i]));
                end
            end
            if (s == ST_DOT) begin
                n_pipe.cdot = 34'($signed(cur.prod[0])) + 34'($signed(cur.prod[1]))
                            + 34'($signed(cur.prod[2]));
            end
            // View behind the surface: flip the normal and swap the indexes.
            if (s == ST_FLIP) begin
                pin  = (r_index_inside == '0) ? 16'd1 : r_index_inside;
                pout = (r_index_outside == '0) ? 16'd1 : r_index_outside;
                neg  = cur.cdot[33];
                n_pipe.p = neg ? pout : pin;
                n_pipe.q = neg ? pin : pout;
                for (int i = 0; i < 3; i++) begin
                    n_pipe.n[i] = neg ? 17'(17'd0 - cur.n[i]) : cur.n[i];
                end
                mag = neg ? 34'(34'd0 - cur.cdot) : cur.cdot;
                cm  = 64'(mag);
                if (cm > CM_MAX) begin
                    cm = CM_MAX;
                end
                n_pipe.ci = 31'((cm >> QSHR) << QSHL);
            end
            if (s == ST_SQ) begin
                n_pipe.cisq = 61'(cur.ci) * 61'(cur.ci);
                n_pipe.qq   = 32'(cur.q) * 32'(cur.q);
                n_pipe.den  = 32'(cur.p) * 32'(cur.p);
            end
            if (s == ST_S30) begin
                n_pipe.s30 = 31'((ONE60 - cur.cisq) >> 30);
            end
            if (s == ST_NUM) begin
                n_pipe.num = 63'(cur.s30) * 63'(cur.qq);
            end
            // Sine squared above one means total reflection.
            if (s == ST_TIR) begin
                wide          = 64'(cur.den) << 30;
                n_pipe.tir    = 64'(cur.num) > wide;
                n_pipe.d1_rem = n_pipe.tir ? '0 : wide - 64'(cur.num);
                n_pipe.d1_quo = '0;
            end
            if (s >= ST_D1 && s < ST_D1 + 31) begin
                dv = div_step(cur.d1_rem, 80'(cur.den) << JD1);
                n_pipe.d1_rem      = dv.rem;
                n_pipe.d1_quo[JD1] = dv.q;
            end
            if (s == ST_SQ1I) begin
                n_pipe.sq_x = 64'(cur.d1_quo) << 30;
                n_pipe.sq_r = '0;
            end
            if ((s >= ST_SQ1 && s < ST_SQ1 + 31) || (s >= ST_SQ2 && s < ST_SQ2 + 32)) begin
                sq = sqrt_step(cur.sq_x, cur.sq_r, 64'd1 << (2 * ES));
                n_pipe.sq_x = sq.x;
                n_pipe.sq_r = sq.r;
            end
            if (s == ST_FMUL) begin
                n_pipe.ct  = cur.sq_r[30:0];
                n_pipe.pci = 47'(cur.p) * 47'(cur.ci);
                n_pipe.qci = 47'(cur.q) * 47'(cur.ci);
                n_pipe.qct = 47'(cur.q) * 47'(cur.sq_r[30:0]);
                n_pipe.pct = 47'(cur.p) * 47'(cur.sq_r[30:0]);
            end
            if (s == ST_FSET) begin
                n_pipe.diff   = 48'(cur.pct) - 48'(cur.qci);
                a_s           = cur.pci[46:16];
                b_s           = cur.qct[46:16];
                n_pipe.fa_sum = 32'(a_s) + 32'(b_s);
                n_pipe.fa_rem = 64'((a_s > b_s) ? a_s - b_s : b_s - a_s) << 30;
                n_pipe.fa_quo = '0;
                a_s           = cur.qci[46:16];
                b_s           = cur.pct[46:16];
                n_pipe.fb_sum = 32'(a_s) + 32'(b_s);
                n_pipe.fb_rem = 64'((a_s > b_s) ? a_s - b_s : b_s - a_s) << 30;
                n_pipe.fb_quo = '0;
            end
            if (s >= ST_FD && s < ST_FD + 31) begin
                dv = div_step(cur.fa_rem, 80'(cur.fa_sum) << JFD);
                n_pipe.fa_rem      = dv.rem;
                n_pipe.fa_quo[JFD] = dv.q;
                dv = div_step(cur.fb_rem, 80'(cur.fb_sum) << JFD);
                n_pipe.fb_rem      = dv.rem;
                n_pipe.fb_quo[JFD] = dv.q;
            end
            if (s == ST_MN) begin
                for (int i = 0; i < 3; i++) begin
                    n_pipe.mprod[i] = 64'($signed(cur.diff)) * 64'($signed(cur.n[i]));
                    n_pipe.qv[i]    = 33'($signed({1'b0, cur.q})) * 33'($signed(cur.v[i]));
                end
            end
            // Truncate toward zero: bias negatives before the arithmetic shift.
            if (s == ST_TZ) begin
                for (int i = 0; i < 3; i++) begin
                    wide = cur.mprod[i] + (cur.mprod[i][63] ? ONE30 - 64'd1 : 64'd0);
                    n_pipe.tz[i] = 36'($signed(wide) >>> 30);
                end
            end
            if (s == ST_W) begin
                for (int i = 0; i < 3; i++) begin
                    n_pipe.w[i] = 36'd0 - {{3{cur.qv[i][32]}}, cur.qv[i]} - cur.tz[i];
                end
            end
            if (s == ST_ABS) begin
                for (int i = 0; i < 3; i++) begin
                    n_pipe.wneg[i] = cur.w[i][35];
                    n_pipe.aw[i]   = cur.w[i][35] ? 36'd0 - cur.w[i] : cur.w[i];
                end
            end
            if (s == ST_MX) begin
                n_pipe.mx = (cur.aw[0] > cur.aw[1]) ? cur.aw[0] : cur.aw[1];
                if (cur.aw[2] > n_pipe.mx) begin
                    n_pipe.mx = cur.aw[2];
                end
            end
            // Scale the vector below 2^30 before squaring.
            if (s == ST_K) begin
                n_pipe.k = '0;
                for (int b = 30; b < 36; b++) begin
                    if (cur.mx[b]) begin
                        n_pipe.k = 3'(b - 29);
                    end
                end
            end
            if (s == ST_AM) begin
                for (int i = 0; i < 3; i++) begin
                    n_pipe.am[i] = 30'(cur.aw[i] >> cur.k);
                end
            end
            if (s == ST_SQS) begin
                for (int i = 0; i < 3; i++) begin
                    n_pipe.sqs[i] = 60'(cur.am[i]) * 60'(cur.am[i]);
                end
            end
            if (s == ST_LSUM) begin
                n_pipe.lsum = 62'(cur.sqs[0]) + 62'(cur.sqs[1]) + 62'(cur.sqs[2]);
            end
            if (s == ST_SQ2I) begin
                n_pipe.sq_x = 64'(cur.lsum);
                n_pipe.sq_r = '0;
            end
            // Squared reflectances; a zero denominator counts as full reflection.
            if (s == ST_FR) begin
                n_pipe.ra = (cur.fa_sum == '0) ? 31'(ONE30)
                          : 31'((62'(cur.fa_quo) * 62'(cur.fa_quo)) >> 30);
                n_pipe.rb = (cur.fb_sum == '0) ? 31'(ONE30)
                          : 31'((62'(cur.fb_quo) * 62'(cur.fb_quo)) >> 30);
            end
            if (s == ST_KR) begin
                n_pipe.kr = 31'((32'(cur.ra) + 32'(cur.rb)) >> 1);
            end
            if (s == ST_TRANS) begin
                n_pipe.trans = (64'(cur.kr) >= ONE30) ? '0 : 31'(ONE30) - cur.kr;
            end
            if (s == ST_D2I) begin
                n_pipe.len = cur.sq_r[31:0];
                for (int i = 0; i < 3; i++) begin
                    n_pipe.d2_rem[i] = 64'(cur.am[i]) << F;
                    n_pipe.d2_quo[i] = '0;
                end
            end
            if (s >= ST_D2 && s <= ST_D2 + F) begin
                for (int i = 0; i < 3; i++) begin
                    dv = div_step(cur.d2_rem[i], 80'(cur.len) << JD2);
                    n_pipe.d2_rem[i]      = dv.rem;
                    n_pipe.d2_quo[i][JD2] = dv.q;
                end
            end
            // Saturate each component to the 16-bit signed range; a zero length gives zero.
            if (s == ST_T) begin
                for (int i = 0; i < 3; i++) begin
                    m = cur.d2_quo[i];
                    if (cur.len == '0) begin
                        n_pipe.t[i] = '0;
                    end else if (cur.wneg[i]) begin
                        n_pipe.t[i] = (m > 31'd32768) ? 16'h8000 : 16'(31'd0 - m);
                    end else begin
                        n_pipe.t[i] = (m > 31'd32767) ? 16'h7FFF : 16'(m);
                    end
                end
            end
            if (s == ST_NT) begin
                for (int i = 0; i < 3; i++) begin
                    n_pipe.prod[i] = 32'($signed(cur.n[i])) * 32'($signed(cur.t[i]));
                end
            end
            if (s == ST_DN) begin
                n_pipe.dn = 34'($signed(cur.prod[0])) + 34'($signed(cur.prod[1]))
                          + 34'($signed(cur.prod[2]));
            end
            if (s == ST_COS) begin
                mag = cur.dn[33] ? 34'(34'd0 - cur.dn) : cur.dn;
                n_pipe.cosq = 48'((64'(mag) >> QSHR) << QSHL);
            end
            // Anything at or above 2^24 in the quotient saturates.
            if (s == ST_SCI) begin
                n_pipe.sc_rem = 64'(cur.trans) << 16;
                n_pipe.sc_sat = {16'b0, n_pipe.sc_rem} >= (80'(cur.cosq) << 24);
                n_pipe.sc_quo = '0;
            end
            if (s >= ST_SC && s < ST_SC + 24) begin
                dv = div_step(cur.sc_rem, 80'(cur.cosq) << JSC);
                n_pipe.sc_rem      = dv.rem;
                n_pipe.sc_quo[JSC] = dv.q;
            end
            if (s == ST_FIN) begin
                n_pipe.res.trans_x           = cur.t[0];
                n_pipe.res.trans_y           = cur.t[1];
                n_pipe.res.trans_z           = cur.t[2];
                n_pipe.res.transmit_fraction = cur.trans[30:15];
                n_pipe.res.radiance_scale    = (cur.trans == '0) ? '0
                                             : cur.sc_sat ? SCALE_MAX : cur.sc_quo;
                n_pipe.res.total_reflect     = 1'b0;
                if (cur.tir) begin
                    n_pipe.res               = '0;
                    n_pipe.res.total_reflect = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_pipe[s+1] <= n_pipe;
        end
    end

    assign o_done = r_vld[DEPTH-1];
    assign o_res  = r_pipe[DEPTH-1].res;

endmodule

`default_nettype wire

// ===== tb/fresnel_refraction_unit_chk.sv =====
// Checker for the Fresnel refraction unit: predicts each result and compares it.
module fresnel_refraction_unit_chk
    import fru_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    input  wire         busy,
    input  t_req        i_req,
    input  wire         o_done,
    input  t_res        o_res,
    input  wire         i_cfg_valid,
    input  wire         o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    output int          fail_count,
    output int          pending_count
);
    localparam int FB = 14;
    localparam longint unsigned Q30 = 64'd1 << 30;

    logic [15:0] idx_in, idx_out;
    t_res        exp_res_q[$];

    function automatic longint unsigned mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint shr_mag(longint x, int k);
        longint unsigned m;
        m = mag(x) >> k;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned to_q30(longint unsigned m);
        return m << (30 - 2 * FB);
    endfunction

    function automatic longint unsigned refl_sq(longint unsigned a, longint unsigned b);
        longint unsigned as_, bs, sum, dif, r;
        as_ = a >> 16;
        bs  = b >> 16;
        sum = as_ + bs;
        dif = as_ > bs ? as_ - bs : bs - as_;
        if (sum == 0) return Q30;
        r = (dif << 30) / sum;
        return (r * r) >> 30;
    endfunction

    function automatic t_res refract(t_req rq, logic [15:0] ins, logic [15:0] outs);
        t_res            r;
        longint          n[3], v[3], w[3], t[3];
        longint unsigned p, q, tmp, cm, ci, s30, num, den, ct, trans, kr, cosq;
        longint unsigned scale, len, mx, m;
        longint          cdot, diff, dn, c;
        int              k;
        r = '0;
        n[0] = rq.normal_x; n[1] = rq.normal_y; n[2] = rq.normal_z;
        v[0] = rq.view_x;   v[1] = rq.view_y;   v[2] = rq.view_z;
        p = ins == 0 ? 1 : ins;
        q = outs == 0 ? 1 : outs;
        cdot = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
        // view behind the surface: flip normal, invert ratio
        if (cdot < 0) begin
            tmp = p; p = q; q = tmp;
            for (int i = 0; i < 3; i++) n[i] = -n[i];
        end
        cm = mag(cdot);
        if (cm > (64'd1 << (2 * FB))) cm = 64'd1 << (2 * FB);
        ci = to_q30(cm);
        s30 = ((Q30 << 30) - ci * ci) >> 30;
        num = s30 * q * q;
        den = p * p;
        if (num > (den << 30)) begin
            r.total_reflect = 1'b1;
            return r;
        end
        ct = int_sqrt((((den << 30) - num) / den) << 30);
        diff = longint'(p * ct) - longint'(q * ci);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            w[i] = -longint'(q) * v[i] - shr_mag(diff * n[i], 30);
            if (mag(w[i]) > mx) mx = mag(w[i]);
        end
        k = 0;
        while ((mx >> k) >= Q30) k++;
        len = 0;
        for (int i = 0; i < 3; i++) begin
            w[i] = shr_mag(w[i], k);
            len += mag(w[i]) * mag(w[i]);
        end
        len = int_sqrt(len);
        for (int i = 0; i < 3; i++) begin
            c = 0;
            if (len != 0) begin
                m = (mag(w[i]) << FB) / len;
                if (w[i] < 0) c = m > 32768 ? -32768 : -longint'(m);
                else c = m > 32767 ? 32767 : longint'(m);
            end
            t[i] = c;
        end
        r.trans_x = t[0][15:0];
        r.trans_y = t[1][15:0];
        r.trans_z = t[2][15:0];
        kr = (refl_sq(p * ci, q * ct) + refl_sq(q * ci, p * ct)) >> 1;
        trans = kr >= Q30 ? 0 : Q30 - kr;
        r.transmit_fraction = 16'(trans >> 15);
        dn = n[0] * t[0] + n[1] * t[1] + n[2] * t[2];
        cosq = to_q30(mag(dn));
        if (cosq == 0) begin
            scale = trans != 0 ? 64'(SCALE_MAX) : 0;
        end else begin
            scale = (trans << 16) / cosq;
            if (scale > 64'(SCALE_MAX)) scale = 64'(SCALE_MAX);
        end
        r.radiance_scale = 24'(scale);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_count = exp_res_q.size();

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            idx_in  <= INDEX_RESET;
            idx_out <= INDEX_RESET;
        end else begin
            // config only moves while idle, so items see the settled mirror
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_INDEX_INSIDE) idx_in <= i_cfg_data;
                else idx_out <= i_cfg_data;
            end
            if (start && !busy) exp_res_q.push_back(refract(i_req, idx_in, idx_out));
            if (o_done) begin
                if (exp_res_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    e = exp_res_q.pop_front();
                    if (o_res.trans_x !== e.trans_x)
                        report("trans_x", o_res.trans_x, e.trans_x);
                    if (o_res.trans_y !== e.trans_y)
                        report("trans_y", o_res.trans_y, e.trans_y);
                    if (o_res.trans_z !== e.trans_z)
                        report("trans_z", o_res.trans_z, e.trans_z);
                    if (o_res.transmit_fraction !== e.transmit_fraction)
                        report("transmit_fraction", o_res.transmit_fraction,
                               e.transmit_fraction);
                    if (o_res.radiance_scale !== e.radiance_scale)
                        report("radiance_scale", o_res.radiance_scale, e.radiance_scale);
                    if (o_res.total_reflect !== e.total_reflect)
                        report("total_reflect", o_res.total_reflect, e.total_reflect);
                end
            end
        end
    end
endmodule

// ===== tb/fresnel_refraction_unit_tb.sv =====
// Top of the Fresnel refraction unit testbench: clock, reset, stimulus and verdict.
module fresnel_refraction_unit_tb;
    import fru_pkg::*;

    localparam int DRAIN_CYCLES = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_done;
    t_res        o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending_count;
    int          idle_pct;

    fresnel_refraction_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_done(o_done), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    fresnel_refraction_unit_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_done(o_done), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Drop start through random gaps, then present one transaction and wait
    // for it to be taken. Consecutive items keep start high without a dip.
    task automatic send_hit(t_req rq);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop valid after the write so back-to-back writes stay apart.
    task automatic write_index(logic idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop start and let every transaction in flight come out.
    task automatic drain;
        start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_req make_hit(int nx, int ny, int nz, int vx, int vy, int vz);
        t_req r;
        r.normal_x = 16'(nx); r.normal_y = 16'(ny); r.normal_z = 16'(nz);
        r.view_x   = 16'(vx); r.view_y   = 16'(vy); r.view_z   = 16'(vz);
        return r;
    endfunction

    // Random unit vector in Q2.14, built by scaling a random lattice point.
    task automatic unit_vec(output int x, output int y, output int z);
        int  a, b, c;
        real l;
        do begin
            a = $urandom_range(32768) - 16384;
            b = $urandom_range(32768) - 16384;
            c = $urandom_range(32768) - 16384;
            l = $sqrt(real'(a) * a + real'(b) * b + real'(c) * c);
        end while (l < 100.0);
        x = $rtoi(16384.0 * a / l);
        y = $rtoi(16384.0 * b / l);
        z = $rtoi(16384.0 * c / l);
    endtask

    function automatic int raw_comp();
        return $urandom_range(32768) - 16384;
    endfunction

    task automatic random_hit;
        int nx, ny, nz, vx, vy, vz;
        unit_vec(nx, ny, nz);
        unit_vec(vx, vy, vz);
        case ($urandom_range(9))
            0: begin
                // noise: arbitrary in-range components, non-unit lengths
                nx = raw_comp(); ny = raw_comp(); nz = raw_comp();
                vx = raw_comp(); vy = raw_comp(); vz = raw_comp();
            end
            1: begin
                // near-normal incidence from either side
                vx = nx + $urandom_range(64) - 32;
                vy = ny + $urandom_range(64) - 32;
                vz = $urandom_range(1) ? nz : -nz;
            end
            default: ;
        endcase
        send_hit(make_hit(nx, ny, nz, vx, vy, vz));
    endtask

    initial begin
        logic [15:0] ins_tab[8] = '{16'd4096, 16'd6144, 16'd4096, 16'd1024,
                                    16'd65535, 16'd65535, 16'd1024, 16'd5461};
        logic [15:0] out_tab[8] = '{16'd4096, 16'd4096, 16'd6144, 16'd65535,
                                    16'd1024, 16'd65535, 16'd1024, 16'd4096};
        int per_phase;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_INDEX_INSIDE;
        i_cfg_data  = '0;
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset indexes first, then a denser outside for reflection.
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                drain();
                write_index(CFG_INDEX_OUTSIDE, 16'd6144);
            end
            send_hit(make_hit(0, 0, 16384, 0, 0, 16384));        // normal incidence
            send_hit(make_hit(0, 0, 16384, 0, 0, -16384));       // from behind
            send_hit(make_hit(0, 0, 16384, 16384, 0, 0));        // grazing
            send_hit(make_hit(0, 0, 0, 0, 0, 0));                // degenerate
            send_hit(make_hit(-16384, 0, 0, 11585, 0, -11585));  // 45 degrees
            send_hit(make_hit(0, -16384, 0, 0, 4096, -15864));   // shallow, behind
            send_hit(make_hit(16384, 16384, 16384, 16384, 16384, 16384)); // clamp
            send_hit(make_hit(-16384, -16384, -16384, 16384, -16384, 16384));
            send_hit(make_hit(0, 16384, 0, 0, 1000, 16353));
            send_hit(make_hit(0, 16384, 0, 16353, 1000, 0));
            send_hit(make_hit(9459, 9459, 9459, -9459, 9459, -9459));
        end
        drain();

        // Random phases over several index settings, extremes included.
        per_phase = 1200 / 8;
        for (int ph = 0; ph < 8; ph++) begin
            write_index(CFG_INDEX_INSIDE, ins_tab[ph]);
            write_index(CFG_INDEX_OUTSIDE, out_tab[ph]);
            for (int i = 0; i < per_phase; i++) begin
                if (ph < 3) idle_pct = 22;
                else if (ph < 6) idle_pct = 58;
                else idle_pct = 0;
                random_hit();
            end
            drain();
        end

        if (fail_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
